@@ rtl/core/chs_pkg.sv @@
`default_nettype none

package chs_pkg;

	// command codes
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_FWD  = 2'd1;
	localparam logic [1:0] CMD_BACK = 2'd2;

	localparam logic [16:0] DAY_SECONDS = 17'd86400;
	localparam logic [16:0] MAX_STEP    = 17'd43200;
	localparam logic [11:0] YEAR_LOW    = 12'd1900;
	localparam logic [11:0] YEAR_HIGH   = 12'd2100;

	localparam logic [11:0] YEAR_RESET  = 12'd1901;
	localparam logic [3:0]  MONTH_RESET = 4'd1;
	localparam logic [4:0]  DAY_RESET   = 5'd1;
	localparam logic [16:0] SECS_RESET  = 17'd0;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [16:0] secs;
	} date_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [11:0] year_in;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
		logic [16:0] time_in;
		logic [16:0] step_seconds;
	} cmd_t;

	typedef struct packed {
		logic        ok;
		logic [11:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [16:0] time_out;
	} rsp_t;

	// length of a month; the leap test is only exact for 1901..2099, the only
	// years for which the result is ever used (2000 is a leap year)
	function automatic logic [4:0] days_in(input logic [11:0] year, input logic [3:0] month);
		logic [4:0] len;
		unique case (month)
			4'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
			4'd4:    len = 5'd30;
			4'd6:    len = 5'd30;
			4'd9:    len = 5'd30;
			4'd11:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/chs_valid.sv @@
`default_nettype none

module chs_valid
	import chs_pkg::*;
(
	input  date_t date,
	output logic  valid
);

	assign valid = (date.year > YEAR_LOW) && (date.year < YEAR_HIGH)
		&& (date.month >= 4'd1) && (date.month <= 4'd12)
		&& (date.day >= 5'd1) && (date.day <= days_in(date.year, date.month))
		&& (date.secs <= DAY_SECONDS);

endmodule

`default_nettype wire

@@ rtl/core/chs_next.sv @@
`default_nettype none

module chs_next
	import chs_pkg::*;
(
	input  cmd_t  cmd,
	input  date_t cur,
	input  logic  cur_ok,
	output date_t nxt,
	output logic  taken
);

	localparam logic [17:0] DAY18 = {1'b0, DAY_SECONDS};

	logic [17:0] fwd_sum;
	logic [17:0] fwd_wrap;
	logic [17:0] back_wrap;
	logic [4:0]  dim;
	logic [4:0]  prev_dim;
	logic        step_ok;

	always_comb begin
		fwd_sum   = {1'b0, cur.secs} + {1'b0, cmd.step_seconds};
		fwd_wrap  = fwd_sum - DAY18;
		back_wrap = {1'b0, cur.secs} + DAY18 - {1'b0, cmd.step_seconds};
		dim       = days_in(cur.year, cur.month);
		prev_dim  = days_in(cur.year, cur.month - 4'd1);
		step_ok   = (cmd.step_seconds <= MAX_STEP) && cur_ok;
		nxt       = cur;
		taken     = 1'b0;
		unique case (cmd.command)
			CMD_LOAD: begin
				taken     = 1'b1;
				nxt.year  = cmd.year_in;
				nxt.month = cmd.month_in;
				nxt.day   = cmd.day_in;
				nxt.secs  = cmd.time_in;
			end
			CMD_FWD: begin
				if (step_ok) begin
					taken = 1'b1;
					if (fwd_sum <= DAY18) begin
						nxt.secs = fwd_sum[16:0];
					end else begin
						nxt.secs = fwd_wrap[16:0];
						if (cur.day < dim) begin
							nxt.day = cur.day + 5'd1;
						end else begin
							nxt.day = 5'd1;
							if (cur.month < 4'd12) begin
								nxt.month = cur.month + 4'd1;
							end else begin
								nxt.month = 4'd1;
								nxt.year  = cur.year + 12'd1;
							end
						end
					end
				end
			end
			CMD_BACK: begin
				if (step_ok) begin
					taken = 1'b1;
					if (cmd.step_seconds <= cur.secs) begin
						nxt.secs = cur.secs - cmd.step_seconds;
					end else begin
						nxt.secs = back_wrap[16:0];
						if (cur.day > 5'd1) begin
							nxt.day = cur.day - 5'd1;
						end else if (cur.month > 4'd1) begin
							nxt.month = cur.month - 4'd1;
							nxt.day   = prev_dim;
						end else begin
							nxt.month = 4'd12;
							nxt.day   = 5'd31;
							nxt.year  = cur.year - 12'd1;
						end
					end
				end
			end
			default: begin
				taken = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/calendar_hour_stepper_core.sv @@
`default_nettype none

// channel  | handshake             | payload         | role
// ---------+-----------------------+-----------------+-----------------------------
// cmd      | cmd_valid / cmd_ready | cmd   (cmd_t)   | load, step forward, step back
// rsp      | rsp_valid / rsp_ready | rsp   (rsp_t)   | ok flag and stored date/time
//
// one command per cycle sustained while rsp is not stalled; a command reaches rsp
// through the input register, then the result register holding the updated date
// the date/time state updates in the same edge that loads the result
// register, so the next command always sees the result of the previous one
// reset: state returns to 1901-01-01, 0 s; both pipeline stages empty
// a stalled rsp holds its result; cmd_ready stays high while the input
// register is empty or moves forward in the same cycle

module calendar_hour_stepper_core
	import chs_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,

	input  wire  cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,

	output logic rsp_valid,
	input  wire  rsp_ready,
	output rsp_t rsp
);

	// input register
	logic  valid_s1;
	cmd_t  cmd_s1;

	// stored calendar state and result register
	date_t state_q;
	logic  rsp_valid_q;
	rsp_t  rsp_q;

	// datapath
	logic  cur_ok;
	logic  new_ok;
	logic  taken;
	date_t nxt;
	logic  advance;

	// result register frees up when empty or being taken this cycle
	assign advance   = !rsp_valid_q || rsp_ready;
	assign cmd_ready = !valid_s1 || advance;

	// validity of the date before the command gates any step
	chs_valid u_cur_valid (
		.date  (state_q),
		.valid (cur_ok)
	);

	chs_next u_next (
		.cmd    (cmd_s1),
		.cur    (state_q),
		.cur_ok (cur_ok),
		.nxt    (nxt),
		.taken  (taken)
	);

	// ok reports the date after the command
	chs_valid u_new_valid (
		.date  (nxt),
		.valid (new_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			rsp_valid_q   <= 1'b0;
			state_q.year  <= YEAR_RESET;
			state_q.month <= MONTH_RESET;
			state_q.day   <= DAY_RESET;
			state_q.secs  <= SECS_RESET;
		end else begin
			if (cmd_ready) begin
				valid_s1 <= cmd_valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
				if (valid_s1) begin
					state_q <= nxt;
				end
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
		if (advance && valid_s1) begin
			rsp_q.ok        <= taken && new_ok;
			rsp_q.year_out  <= nxt.year;
			rsp_q.month_out <= nxt.month;
			rsp_q.day_out   <= nxt.day;
			rsp_q.time_out  <= nxt.secs;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

@@ rtl/core/chs_checker.sv @@
`default_nettype none

module chs_checker
	import chs_pkg::*;
(
	input wire  clk,
	input wire  arst_n,
	input wire  cmd_valid,
	input wire  cmd_ready,
	input wire  rsp_valid,
	input wire  rsp_ready,
	input rsp_t rsp
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// a fresh result follows a command transfer through the input register
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd_valid && cmd_ready, 2))
		else $error("rsp without a matching command transfer");

	// ok only ever reports a valid calendar date
	a_ok_date: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.ok |->
			rsp.year_out > YEAR_LOW && rsp.year_out < YEAR_HIGH
			&& rsp.month_out >= 4'd1 && rsp.month_out <= 4'd12
			&& rsp.day_out >= 5'd1
			&& rsp.day_out <= days_in(rsp.year_out, rsp.month_out)
			&& rsp.time_out <= DAY_SECONDS)
		else $error("ok set on an invalid date");

endmodule

bind calendar_hour_stepper_core chs_checker u_chs_checker (.*);

`default_nettype wire
